// ----- rtl/core/bcrc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcrc_pkg: shared types, codes and crc helpers for the block record checker
// beat structs, result kinds, status codes and per-byte crc update functions
// ----------------------------------------------------------------------------
package bcrc_pkg;

  // config port
  localparam int CfgIndexWidth = 1;
  localparam int CfgDataWidth  = 32;
  localparam logic [CfgIndexWidth-1:0] CFG_FILE_CRC  = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CFG_FORMAT_ID = 1'b1;

  // result queue
  localparam int QueueDepth    = 4;
  localparam int QueuePtrWidth = $clog2(QueueDepth);
  localparam int QueueCntWidth = $clog2(QueueDepth + 1);

  // crc constants
  localparam logic [15:0] Crc16Init = 16'hFFFF;
  localparam logic [15:0] Crc16Poly = 16'h1021;
  localparam logic [31:0] Crc32Init = 32'hFFFF_FFFF;
  localparam logic [31:0] Crc32Poly = 32'hEDB8_8320;

  // result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_FINAL  = 2'd2;

  // final status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FILE_CRC   = 3'd1;
  localparam logic [2:0] ST_HDR_TRUNC  = 3'd2;
  localparam logic [2:0] ST_DATA_TRUNC = 3'd3;
  localparam logic [2:0] ST_BLOCK_CRC  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_area;
  } bcrc_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [31:0] block_address;
    logic [31:0] block_length;
    logic [15:0] trailer_crc;
    logic        block_crc_ok;
    logic [2:0]  status;
    logic        all_blocks_verified;
    logic        run_last;
  } bcrc_out_t;

  // up to two results written by the parser in one cycle, second only with first
  typedef struct packed {
    logic      first_valid;
    logic      second_valid;
    bcrc_out_t first;
    bcrc_out_t second;
  } bcrc_push_t;

  // crc-16/ccitt-false, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ Crc16Poly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // reflected crc-32, lsb first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ({1'b0, c[31:1]} ^ Crc32Poly) : {1'b0, c[31:1]};
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/bcrc_out_queue.sv -----
// ----------------------------------------------------------------------------
// bcrc_out_queue: small result queue between parser and output channel
// takes up to two results per cycle; while out_stall is low, hands out one beat per cycle
// ----------------------------------------------------------------------------
module bcrc_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  bcrc_pkg::bcrc_push_t push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output bcrc_pkg::bcrc_out_t out_data
);
  import bcrc_pkg::*;

  bcrc_out_t                entries [QueueDepth];
  logic [QueuePtrWidth-1:0] wr_ptr;
  logic [QueuePtrWidth-1:0] rd_ptr;
  logic [QueueCntWidth-1:0] count;
  logic [QueueCntWidth-1:0] push_cnt;
  logic                     pop;

  assign push_cnt  = QueueCntWidth'(push.first_valid) + QueueCntWidth'(push.second_valid);
  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  // space for the worst case of two results
  assign room      = (count <= QueueCntWidth'(QueueDepth - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt[QueuePtrWidth-1:0];
      rd_ptr <= rd_ptr + QueuePtrWidth'(pop);
      count  <= count + push_cnt - QueueCntWidth'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.second_valid) begin
      entries[wr_ptr + QueuePtrWidth'(1)] <= push.second;
    end
  end

endmodule

// ----- rtl/core/bcrc_parser.sv -----
// ----------------------------------------------------------------------------
// bcrc_parser: input register plus one-pass block parser and crc update
// splits the byte stream into address, length, data and crc fields
// ----------------------------------------------------------------------------
module bcrc_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bcrc_pkg::bcrc_in_t  in_data,
  input  logic [31:0]         expected_file_crc,
  input  logic [7:0]          format_id,
  input  logic                room,
  output bcrc_pkg::bcrc_push_t push
);
  import bcrc_pkg::*;

  typedef enum logic [1:0] {PH_ADDR, PH_LEN, PH_DATA, PH_CRC} phase_t;

  logic        s1_valid;
  bcrc_in_t    s1_beat;
  logic        adv;

  phase_t      phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] address_reg, address_reg_next;
  logic [31:0] length_reg, length_reg_next;
  logic [15:0] block_crc, block_crc_next;
  logic [31:0] file_crc, file_crc_next;
  logic [15:0] trailer_reg, trailer_reg_next;
  logic [2:0]  first_error, first_error_next;
  logic        verified_flag, verified_flag_next;

  logic [7:0]  b;
  logic [15:0] stored_shift;
  logic        data_hit, rec_hit, crc_ok;
  logic [2:0]  final_status;
  bcrc_out_t   main_res, final_res;

  assign b        = s1_beat.data_byte;
  assign adv      = s1_valid && room;
  assign in_stall = s1_valid && !room;
  assign stored_shift = {trailer_reg[7:0], b};

  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    address_reg_next    = address_reg;
    length_reg_next     = length_reg;
    block_crc_next      = block_crc;
    trailer_reg_next    = trailer_reg;
    first_error_next    = first_error;
    verified_flag_next  = verified_flag;
    file_crc_next       = crc32_byte(file_crc, b);
    data_hit            = 1'b0;
    rec_hit             = 1'b0;
    crc_ok              = 1'b0;

    case (phase)
      PH_ADDR: begin
        address_reg_next = {address_reg[23:0], b};
        if (byte_count == 32'd3) begin
          phase_next      = PH_LEN;
          byte_count_next = '0;
        end else begin
          byte_count_next = byte_count + 32'd1;
        end
      end
      PH_LEN: begin
        length_reg_next = {length_reg[23:0], b};
        if (byte_count == 32'd3) begin
          // empty block skips straight to its crc
          phase_next      = (length_reg_next == '0) ? PH_CRC : PH_DATA;
          byte_count_next = '0;
        end else begin
          byte_count_next = byte_count + 32'd1;
        end
      end
      PH_DATA: begin
        data_hit       = 1'b1;
        block_crc_next = crc16_byte(block_crc, b);
        if (byte_count + 32'd1 == length_reg) begin
          phase_next      = PH_CRC;
          byte_count_next = '0;
        end else begin
          byte_count_next = byte_count + 32'd1;
        end
      end
      PH_CRC: begin
        trailer_reg_next = stored_shift;
        if (byte_count == 32'd1) begin
          rec_hit = 1'b1;
          crc_ok  = (block_crc == stored_shift);
          if (!crc_ok) begin
            if (format_id == 8'd0) begin
              if (first_error == ST_OK) begin
                first_error_next = ST_BLOCK_CRC;
              end
            end else begin
              verified_flag_next = 1'b0;
            end
          end
          phase_next          = PH_ADDR;
          byte_count_next     = '0;
          address_reg_next    = '0;
          length_reg_next     = '0;
          trailer_reg_next    = '0;
          block_crc_next      = Crc16Init;
        end else begin
          byte_count_next = byte_count + 32'd1;
        end
      end
      default: begin
      end
    endcase

    // final status from the state after this byte
    if ((file_crc_next ^ Crc32Init) != expected_file_crc) begin
      final_status = ST_FILE_CRC;
    end else if (first_error_next != ST_OK) begin
      final_status = first_error_next;
    end else if (phase_next == PH_ADDR && byte_count_next == '0) begin
      final_status = ST_OK;
    end else begin
      case (phase_next)
        PH_DATA: final_status = (byte_count_next < 32'd2) ? ST_HDR_TRUNC : ST_DATA_TRUNC;
        PH_CRC: begin
          final_status = (length_reg_next == '0 ||
                          (length_reg_next == 32'd1 && byte_count_next == '0))
                         ? ST_HDR_TRUNC : ST_DATA_TRUNC;
        end
        default: final_status = ST_HDR_TRUNC;
      endcase
    end

    main_res       = '0;
    main_res.kind  = data_hit ? KIND_DATA : KIND_RECORD;
    if (data_hit) begin
      main_res.out_byte = b;
    end else begin
      main_res.block_address = address_reg;
      main_res.block_length  = length_reg;
      main_res.trailer_crc   = stored_shift;
      main_res.block_crc_ok  = crc_ok;
    end
    main_res.run_last = !s1_beat.end_of_area;

    final_res                     = '0;
    final_res.kind                = KIND_FINAL;
    final_res.status              = final_status;
    final_res.all_blocks_verified = verified_flag_next;
    final_res.run_last            = 1'b1;

    push.first_valid  = adv && (data_hit || rec_hit || s1_beat.end_of_area);
    push.second_valid = adv && (data_hit || rec_hit) && s1_beat.end_of_area;
    push.first        = (data_hit || rec_hit) ? main_res : final_res;
    push.second       = final_res;

    // end of area starts a fresh stream
    if (s1_beat.end_of_area) begin
      phase_next          = PH_ADDR;
      byte_count_next     = '0;
      address_reg_next    = '0;
      length_reg_next     = '0;
      block_crc_next      = Crc16Init;
      file_crc_next       = Crc32Init;
      trailer_reg_next    = '0;
      first_error_next    = ST_OK;
      verified_flag_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      phase          <= PH_ADDR;
      byte_count     <= '0;
      address_reg    <= '0;
      length_reg     <= '0;
      block_crc      <= Crc16Init;
      file_crc       <= Crc32Init;
      trailer_reg    <= '0;
      first_error    <= ST_OK;
      verified_flag  <= 1'b1;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        phase          <= phase_next;
        byte_count     <= byte_count_next;
        address_reg    <= address_reg_next;
        length_reg     <= length_reg_next;
        block_crc      <= block_crc_next;
        file_crc       <= file_crc_next;
        trailer_reg    <= trailer_reg_next;
        first_error    <= first_error_next;
        verified_flag  <= verified_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_beat <= in_data;
    end
  end

endmodule

// ----- rtl/core/block_record_crc_checker.sv -----
// ----------------------------------------------------------------------------
// block_record_crc_checker: streaming parser and crc checker for the binary
// area of a flash image; emits data bytes, block records and a final status
// ----------------------------------------------------------------------------
//
//   channel   signals                      beat
//   in        in_valid / in_stall          one image byte plus end mark
//   out       out_valid / out_stall        data byte, block record or status
//   cfg       cfg_write / cfg_index        file crc, format id (write only)
//
// one input beat per cycle is taken while the input is not stalled; each beat gives up to two result beats
// the input beat is registered, its results are written to the result queue, and the queue drives the output
// beats that give two results (a data byte or the second crc byte, either with end mark)
//   drain at one result per cycle while out_stall is low, so the output port sets the rate there
// the input stalls only when the four-entry result queue lacks two free slots
// reset is synchronous; no clearing pass, ready the cycle after reset
// ----------------------------------------------------------------------------
module block_record_crc_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bcrc_pkg::bcrc_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bcrc_pkg::bcrc_out_t                 out_data,
  input  logic                                cfg_write,
  input  logic [bcrc_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [bcrc_pkg::CfgDataWidth-1:0]   cfg_data
);
  import bcrc_pkg::*;

  // config registers; the user must write them only while idle, the block does not enforce it
  logic [31:0] expected_file_crc;
  logic [7:0]  format_id;

  // parser to queue handoff
  bcrc_push_t  push;
  logic        room;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_file_crc <= '0;
      format_id         <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FILE_CRC:  expected_file_crc <= cfg_data[31:0];
        CFG_FORMAT_ID: format_id         <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // input register, field tracking, crc-16 per block, crc-32 over the area
  bcrc_parser u_parser (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data           (in_data),
    .expected_file_crc (expected_file_crc),
    .format_id         (format_id),
    .room              (room),
    .push              (push)
  );

  // result queue parts the parser from a stalled output
  bcrc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/bcrc_checker.sv -----
// ----------------------------------------------------------------------------
// bcrc_checker: port-level checks for the block record checker
// watches the result channel and reset behavior
// ----------------------------------------------------------------------------
module bcrc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input bcrc_pkg::bcrc_out_t                 out_data
);
  import bcrc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // final status always closes the run of its input beat
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_FINAL |-> out_data.run_last)
    else $error("final status without run_last");

  // status fields only on final beats, no unused kind code
  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_FINAL |->
      out_data.kind != 2'd3 && out_data.status == ST_OK &&
      !out_data.all_blocks_verified)
    else $error("bad kind or status on non-final beat");

  // nothing pending and input open right after reset
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("state left after reset");

endmodule

bind block_record_crc_checker bcrc_checker u_bcrc_checker (.*);
